// ----- src/traffic_direction_prefix_classifier_defines.svh -----
// Assertion macros shared by the traffic direction classifier RTL.
`ifndef TRAFFIC_DIRECTION_PREFIX_CLASSIFIER_DEFINES_SVH
`define TRAFFIC_DIRECTION_PREFIX_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define TDPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TDPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDPC_ASSERT(lbl, prop, msg)
`define TDPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/tdpc_pkg.sv -----
// Types, codes and helper functions of the traffic direction classifier.
`default_nettype none
package tdpc_pkg;

  localparam int PREFIX_ENTRIES_DEF = 16;

  localparam int ADDR_W      = 64;
  localparam int V4_W        = 32;
  localparam int V6_W        = 128;
  localparam int LEN_W       = 8;
  localparam int IDX_W       = 4;
  localparam int MASK_W      = 12;
  localparam int CNT_W       = 5;
  localparam int ENTRY_CMP_W = 7;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;

  localparam logic [1:0] ACT_CLASSIFY = 2'd0;
  localparam logic [1:0] ACT_LOAD_V4  = 2'd1;
  localparam logic [1:0] ACT_LOAD_V6  = 2'd2;

  localparam logic [1:0] FAM_IPV4 = 2'd0;
  localparam logic [1:0] FAM_IPV6 = 2'd1;

  localparam logic [1:0] DIR_INCOMING = 2'd0;
  localparam logic [1:0] DIR_OUTGOING = 2'd1;
  localparam logic [1:0] DIR_INTERNAL = 2'd2;
  localparam logic [1:0] DIR_EXTERNAL = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MASK_IN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK_OUT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK_INT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK_EXT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_V4_COUNT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_V6_COUNT = 3'd5;

  typedef struct packed {
    logic [MASK_W-1:0] mask_incoming;
    logic [MASK_W-1:0] mask_outgoing;
    logic [MASK_W-1:0] mask_internal;
    logic [MASK_W-1:0] mask_external;
    logic [CNT_W-1:0]  v4_count;
    logic [CNT_W-1:0]  v6_count;
  } cfg_t;

  // A shift of the width or more yields zero, so long lengths give a full mask.
  function automatic logic [V4_W-1:0] v4_netmask(input logic [LEN_W-1:0] len);
    return ~({V4_W{1'b1}} >> len);
  endfunction

  function automatic logic [V6_W-1:0] v6_netmask(input logic [LEN_W-1:0] len);
    return ~({V6_W{1'b1}} >> len);
  endfunction

endpackage
`default_nettype wire

// ----- src/tdpc_prefix_table.sv -----
// Local prefix tables: masked prefix and netmask per slot for both families.
`default_nettype none
module tdpc_prefix_table
  import tdpc_pkg::*;
#(
  parameter int ENTRIES = PREFIX_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           load_v4,
  input  wire logic                           load_v6,
  input  wire logic [IDX_W-1:0]               idx,
  input  wire logic [ADDR_W-1:0]              prefix_hi,
  input  wire logic [ADDR_W-1:0]              prefix_lo,
  input  wire logic [LEN_W-1:0]               prefix_length,
  output logic      [ENTRIES-1:0][V4_W-1:0]   v4_pfx,
  output logic      [ENTRIES-1:0][V4_W-1:0]   v4_mask,
  output logic      [ENTRIES-1:0][V6_W-1:0]   v6_pfx,
  output logic      [ENTRIES-1:0][V6_W-1:0]   v6_mask
);

  logic [ENTRIES-1:0][V4_W-1:0] v4_pfx_r;
  logic [ENTRIES-1:0][V4_W-1:0] v4_mask_r;
  logic [ENTRIES-1:0][V6_W-1:0] v6_pfx_r;
  logic [ENTRIES-1:0][V6_W-1:0] v6_mask_r;
  logic [V4_W-1:0]              v4m;
  logic [V6_W-1:0]              v6m;

  assign v4m = v4_netmask(prefix_length);
  assign v6m = v6_netmask(prefix_length);

  // Slots at or above the table size never match the index, so such loads drop.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (load_v4 && (ENTRY_CMP_W'(idx) == ENTRY_CMP_W'(i))) begin
        v4_pfx_r[i]  <= prefix_lo[V4_W-1:0] & v4m;
        v4_mask_r[i] <= v4m;
      end
      if (load_v6 && (ENTRY_CMP_W'(idx) == ENTRY_CMP_W'(i))) begin
        v6_pfx_r[i]  <= {prefix_hi, prefix_lo} & v6m;
        v6_mask_r[i] <= v6m;
      end
    end
  end

  assign v4_pfx  = v4_pfx_r;
  assign v4_mask = v4_mask_r;
  assign v6_pfx  = v6_pfx_r;
  assign v6_mask = v6_mask_r;

endmodule
`default_nettype wire

// ----- src/tdpc_match_array.sv -----
// Compares one address against every table slot of its family in parallel.
`default_nettype none
module tdpc_match_array
  import tdpc_pkg::*;
#(
  parameter int ENTRIES = PREFIX_ENTRIES_DEF
) (
  input  wire logic [1:0]                   family,
  input  wire logic [ADDR_W-1:0]            addr_hi,
  input  wire logic [ADDR_W-1:0]            addr_lo,
  input  wire logic [ENTRIES-1:0][V4_W-1:0] v4_pfx,
  input  wire logic [ENTRIES-1:0][V4_W-1:0] v4_mask,
  input  wire logic [ENTRIES-1:0][V6_W-1:0] v6_pfx,
  input  wire logic [ENTRIES-1:0][V6_W-1:0] v6_mask,
  output logic      [ENTRIES-1:0]           hit
);

  logic [V4_W-1:0] addr4;
  logic [V6_W-1:0] addr6;

  assign addr4 = addr_lo[V4_W-1:0];
  assign addr6 = {addr_hi, addr_lo};

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      case (family)
        FAM_IPV4: hit[i] = ((addr4 & v4_mask[i]) == v4_pfx[i]);
        FAM_IPV6: hit[i] = ((addr6 & v6_mask[i]) == v6_pfx[i]);
        default:  hit[i] = 1'b0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/tdpc_dir_resolve.sv -----
// Turns the source and destination match flags into a direction and its mask.
`default_nettype none
module tdpc_dir_resolve
  import tdpc_pkg::*;
(
  input  wire logic              src_any,
  input  wire logic              dst_any,
  input  wire cfg_t              cfg,
  output logic      [1:0]        direction,
  output logic      [MASK_W-1:0] field_mask
);

  always_comb begin
    case ({src_any, dst_any})
      2'b11:   direction = DIR_INTERNAL;
      2'b10:   direction = DIR_OUTGOING;
      2'b01:   direction = DIR_INCOMING;
      default: direction = DIR_EXTERNAL;
    endcase
  end

  always_comb begin
    case (direction)
      DIR_INCOMING: field_mask = cfg.mask_incoming;
      DIR_OUTGOING: field_mask = cfg.mask_outgoing;
      DIR_INTERNAL: field_mask = cfg.mask_internal;
      default:      field_mask = cfg.mask_external;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/traffic_direction_prefix_classifier.sv -----
// Throughput: one word per cycle, loads and classifies alike, unless out_ready
// stalls the output; loads give no result.
// Stages: input register, parallel slot compare, count gate and OR, output register.
// Reset: synchronous active low; clears the valid bits and the configuration registers to 0.
// The prefix tables are not cleared; a slot must be loaded before it is counted.
`default_nettype none
`include "traffic_direction_prefix_classifier_defines.svh"
module traffic_direction_prefix_classifier
  import tdpc_pkg::*;
#(
  parameter int PREFIX_ENTRIES = PREFIX_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_action,
  input  wire logic [1:0]         in_addr_family,
  input  wire logic [ADDR_W-1:0]  in_src_addr_hi,
  input  wire logic [ADDR_W-1:0]  in_src_addr_lo,
  input  wire logic [ADDR_W-1:0]  in_dst_addr_hi,
  input  wire logic [ADDR_W-1:0]  in_dst_addr_lo,
  input  wire logic [IDX_W-1:0]   in_entry_index,
  input  wire logic [ADDR_W-1:0]  in_prefix_hi,
  input  wire logic [ADDR_W-1:0]  in_prefix_lo,
  input  wire logic [LEN_W-1:0]   in_prefix_length,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [1:0]         out_direction,
  output logic      [MASK_W-1:0]  out_field_mask,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t cfg_r;

  logic a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  logic a_ready, b_ready, c_ready, o_ready;

  logic [1:0]        a_fam_r;
  logic [ADDR_W-1:0] a_src_hi_r, a_src_lo_r, a_dst_hi_r, a_dst_lo_r;

  logic [1:0]                b_fam_r;
  logic [PREFIX_ENTRIES-1:0] b_src_hit_r, b_dst_hit_r;
  logic [PREFIX_ENTRIES-1:0] b_en;
  logic [CNT_W-1:0]          b_cnt;

  logic c_src_any_r, c_dst_any_r;

  logic [1:0]        out_direction_r;
  logic [MASK_W-1:0] out_field_mask_r;
  logic [1:0]        res_direction;
  logic [MASK_W-1:0] res_field_mask;

  logic in_accept, load_v4, load_v6, cfg_write;
  logic [PREFIX_ENTRIES-1:0] src_hit, dst_hit;

  logic [PREFIX_ENTRIES-1:0][V4_W-1:0] v4_pfx, v4_mask;
  logic [PREFIX_ENTRIES-1:0][V6_W-1:0] v6_pfx, v6_mask;

  // Each stage may take a new word when it is empty or its word moves on.
  assign o_ready  = !out_valid_r || out_ready;
  assign c_ready  = !c_valid_r || o_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  // Loads are taken only when the compare stage is empty or moves, so a classify ahead of
  // a load always compares against the table as it stood before the load.
  assign in_ready = a_ready;

  assign in_accept = in_valid && in_ready;
  assign load_v4   = in_accept && (in_action == ACT_LOAD_V4);
  assign load_v6   = in_accept && (in_action == ACT_LOAD_V6);

  tdpc_prefix_table #(
    .ENTRIES(PREFIX_ENTRIES)
  ) u_table (
    .clk          (clk),
    .load_v4      (load_v4),
    .load_v6      (load_v6),
    .idx          (in_entry_index),
    .prefix_hi    (in_prefix_hi),
    .prefix_lo    (in_prefix_lo),
    .prefix_length(in_prefix_length),
    .v4_pfx       (v4_pfx),
    .v4_mask      (v4_mask),
    .v6_pfx       (v6_pfx),
    .v6_mask      (v6_mask)
  );

  tdpc_match_array #(
    .ENTRIES(PREFIX_ENTRIES)
  ) u_src_cmp (
    .family (a_fam_r),
    .addr_hi(a_src_hi_r),
    .addr_lo(a_src_lo_r),
    .v4_pfx (v4_pfx),
    .v4_mask(v4_mask),
    .v6_pfx (v6_pfx),
    .v6_mask(v6_mask),
    .hit    (src_hit)
  );

  tdpc_match_array #(
    .ENTRIES(PREFIX_ENTRIES)
  ) u_dst_cmp (
    .family (a_fam_r),
    .addr_hi(a_dst_hi_r),
    .addr_lo(a_dst_lo_r),
    .v4_pfx (v4_pfx),
    .v4_mask(v4_mask),
    .v6_pfx (v6_pfx),
    .v6_mask(v6_mask),
    .hit    (dst_hit)
  );

  // Only the first count slots take part; a count above the table size
  // enables every slot.
  assign b_cnt = (b_fam_r == FAM_IPV4) ? cfg_r.v4_count : cfg_r.v6_count;

  always_comb begin
    for (int i = 0; i < PREFIX_ENTRIES; i++) begin
      b_en[i] = (ENTRY_CMP_W'(b_cnt) > ENTRY_CMP_W'(i));
    end
  end

  tdpc_dir_resolve u_resolve (
    .src_any   (c_src_any_r),
    .dst_any   (c_dst_any_r),
    .cfg       (cfg_r),
    .direction (res_direction),
    .field_mask(res_field_mask)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid && (in_action == ACT_CLASSIFY);
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
      if (o_ready) begin
        out_valid_r <= c_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_fam_r    <= in_addr_family;
      a_src_hi_r <= in_src_addr_hi;
      a_src_lo_r <= in_src_addr_lo;
      a_dst_hi_r <= in_dst_addr_hi;
      a_dst_lo_r <= in_dst_addr_lo;
    end
    if (b_ready) begin
      b_fam_r     <= a_fam_r;
      b_src_hit_r <= src_hit;
      b_dst_hit_r <= dst_hit;
    end
    if (c_ready) begin
      c_src_any_r <= |(b_src_hit_r & b_en);
      c_dst_any_r <= |(b_dst_hit_r & b_en);
    end
    if (o_ready) begin
      out_direction_r  <= res_direction;
      out_field_mask_r <= res_field_mask;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_direction  = out_direction_r;
  assign out_field_mask = out_field_mask_r;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write) begin
      case (paddr[PADDR_W-1:2])
        REG_MASK_IN:  cfg_r.mask_incoming <= pwdata[MASK_W-1:0];
        REG_MASK_OUT: cfg_r.mask_outgoing <= pwdata[MASK_W-1:0];
        REG_MASK_INT: cfg_r.mask_internal <= pwdata[MASK_W-1:0];
        REG_MASK_EXT: cfg_r.mask_external <= pwdata[MASK_W-1:0];
        REG_V4_COUNT: cfg_r.v4_count      <= pwdata[CNT_W-1:0];
        REG_V6_COUNT: cfg_r.v6_count      <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_MASK_IN:  prdata = PDATA_W'(cfg_r.mask_incoming);
      REG_MASK_OUT: prdata = PDATA_W'(cfg_r.mask_outgoing);
      REG_MASK_INT: prdata = PDATA_W'(cfg_r.mask_internal);
      REG_MASK_EXT: prdata = PDATA_W'(cfg_r.mask_external);
      REG_V4_COUNT: prdata = PDATA_W'(cfg_r.v4_count);
      REG_V6_COUNT: prdata = PDATA_W'(cfg_r.v6_count);
      default:      prdata = '0;
    endcase
  end

  `TDPC_ASSERT(a_only_classify_enters, in_accept |=> (a_valid_r == $past(in_action == ACT_CLASSIFY)), "compare stage does not hold exactly the accepted classify word")
  `TDPC_ASSERT(b_to_c_advance, (b_valid_r && c_ready) |=> c_valid_r, "word lost between match reduce and resolve stages")
  `TDPC_ASSERT(c_stall_holds, (c_valid_r && !c_ready) |=> (c_valid_r && $stable(c_src_any_r) && $stable(c_dst_any_r)), "stalled resolve stage changed its word")
  `TDPC_ASSERT_ALWAYS(reset_flushes, !rst_n |=> (!a_valid_r && !b_valid_r && !c_valid_r && !out_valid_r), "pipeline not empty after reset")

endmodule
`default_nettype wire
